>>> sv/rie_pkg.sv
// ----------------------------------------------------------------------------
// rie_pkg: shared types and codes of the integer arithmetic execute core
// operation codes, instruction group and function codes, flag state bundle
// ----------------------------------------------------------------------------
package rie_pkg;

    localparam int unsigned NUM_REGS   = 16;
    localparam int unsigned REG_IDX_W  = 4;
    localparam int unsigned DATA_W     = 32;
    localparam int unsigned COST_W     = 3;

    typedef enum logic [1:0] {
        OP_EXEC  = 2'd0,
        OP_LOAD  = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    // instruction groups (bits 15..12)
    localparam logic [3:0] GRP_0    = 4'h0;
    localparam logic [3:0] GRP_2    = 4'h2;
    localparam logic [3:0] GRP_3    = 4'h3;
    localparam logic [3:0] GRP_4    = 4'h4;
    localparam logic [3:0] GRP_6    = 4'h6;
    localparam logic [3:0] GRP_7    = 4'h7;

    // group 3 functions
    localparam logic [3:0] F3_CMPEQ = 4'h0;
    localparam logic [3:0] F3_CMPHS = 4'h2;
    localparam logic [3:0] F3_CMPGE = 4'h3;
    localparam logic [3:0] F3_DIV1  = 4'h4;
    localparam logic [3:0] F3_DMULU = 4'h5;
    localparam logic [3:0] F3_CMPHI = 4'h6;
    localparam logic [3:0] F3_CMPGT = 4'h7;
    localparam logic [3:0] F3_SUB   = 4'h8;
    localparam logic [3:0] F3_SUBC  = 4'hA;
    localparam logic [3:0] F3_ADD   = 4'hC;
    localparam logic [3:0] F3_DMULS = 4'hD;
    localparam logic [3:0] F3_ADDC  = 4'hE;

    // group 6 functions
    localparam logic [3:0] F6_NEGC  = 4'hA;
    localparam logic [3:0] F6_NEG   = 4'hB;
    localparam logic [3:0] F6_EXTUB = 4'hC;
    localparam logic [3:0] F6_EXTUW = 4'hD;
    localparam logic [3:0] F6_EXTSB = 4'hE;
    localparam logic [3:0] F6_EXTSW = 4'hF;

    // group 2 functions
    localparam logic [3:0] F2_DIV0S = 4'h7;
    localparam logic [3:0] F2_CMPSTR = 4'hC;
    localparam logic [3:0] F2_MULUW = 4'hE;
    localparam logic [3:0] F2_MULSW = 4'hF;

    // group 4 low bytes
    localparam logic [7:0] F4_DT    = 8'h10;
    localparam logic [7:0] F4_CMPPZ = 8'h11;
    localparam logic [7:0] F4_CMPPL = 8'h15;

    // group 0
    localparam logic [3:0]  F0_MULL  = 4'h7;
    localparam logic [15:0] W_DIV0U  = 16'h0019;
    localparam logic [7:0]  HI_CMPEQI = 8'h88;

    localparam logic [COST_W-1:0] COST_NONE   = 3'd0;
    localparam logic [COST_W-1:0] COST_SIMPLE = 3'd1;
    localparam logic [COST_W-1:0] COST_MUL    = 3'd4;

    typedef struct packed {
        logic              t;
        logic              q;
        logic              m;
        logic [DATA_W-1:0] mach;
        logic [DATA_W-1:0] macl;
    } flags_t;

    typedef struct packed {
        logic                 wr;
        logic [REG_IDX_W-1:0] dest;
        logic [DATA_W-1:0]    data;
        logic                 ill;
        logic [COST_W-1:0]    cost;
    } wb_t;

endpackage

>>> sv/rie_alu.sv
// ----------------------------------------------------------------------------
// rie_alu: single-pass datapath of the integer arithmetic execute core
// decodes one word and computes register write, flags and accumulator
// ----------------------------------------------------------------------------
module rie_alu (
    input  rie_pkg::op_t                       op,
    input  logic [15:0]                        instr,
    input  logic [rie_pkg::REG_IDX_W-1:0]      idx,
    input  logic [rie_pkg::DATA_W-1:0]         val,
    input  logic [rie_pkg::DATA_W-1:0]         rn,
    input  logic [rie_pkg::DATA_W-1:0]         rm,
    input  rie_pkg::flags_t                    st_in,
    output rie_pkg::flags_t                    st_out,
    output rie_pkg::wb_t                       wb
);

    logic [3:0]  top;
    logic [3:0]  low;
    logic [3:0]  n;
    logic [31:0] imm;
    logic [31:0] shl_val;
    logic [31:0] after;
    logic        carry;
    logic        dq;
    logic [31:0] d;
    logic [31:0] r;
    logic [31:0] z;
    logic [31:0] x;
    logic [31:0] dec;
    logic        mul_signed;
    logic        mul_half;
    logic signed [32:0] ma;
    logic signed [32:0] mb;
    logic signed [65:0] prod;
    logic        res;
    logic [31:0] newv;

    assign top  = instr[15:12];
    assign low  = instr[3:0];
    assign n    = instr[11:8];
    assign imm  = {{24{instr[7]}}, instr[7:0]};
    assign d    = rn - rm;
    assign r    = (top == rie_pkg::GRP_6) ? (z - 32'(st_in.t)) :
                  (low == rie_pkg::F3_SUBC) ? (d - 32'(st_in.t)) :
                  ((rn + rm) + 32'(st_in.t));
    assign z    = 32'd0 - rm;
    assign x    = rn ^ rm;
    assign dec  = rn - 32'd1;

    // divide step
    assign shl_val = {rn[30:0], st_in.t};
    always_comb
    begin
        if (st_in.q == st_in.m)
        begin
            after = shl_val - rm;
            carry = shl_val < rm;
        end
        else
        begin
            after = shl_val + rm;
            carry = after < shl_val;
        end
        dq = rn[31] ^ st_in.m ^ carry;
    end

    // shared multiplier
    assign mul_half   = (top == rie_pkg::GRP_2);
    assign mul_signed = (top == rie_pkg::GRP_3) ? (low == rie_pkg::F3_DMULS)
                                                : (low == rie_pkg::F2_MULSW);
    always_comb
    begin
        if (mul_half)
        begin
            ma = mul_signed ? 33'(signed'(rn[15:0])) : {17'd0, rn[15:0]};
            mb = mul_signed ? 33'(signed'(rm[15:0])) : {17'd0, rm[15:0]};
        end
        else
        begin
            ma = {mul_signed & rn[31], rn};
            mb = {mul_signed & rm[31], rm};
        end
    end
    assign prod = ma * mb;

    always_comb
    begin
        st_out  = st_in;
        wb      = '0;
        res     = 1'b0;
        newv    = '0;
        unique case (op)
            rie_pkg::OP_LOAD:
            begin
                wb.wr   = 1'b1;
                wb.dest = idx;
                wb.data = val;
            end
            rie_pkg::OP_READ:
            begin
                wb.dest = idx;
                wb.data = rn;
            end
            rie_pkg::OP_EXEC:
            begin
                wb.cost = rie_pkg::COST_SIMPLE;
                if (top == rie_pkg::GRP_3)
                begin
                    unique case (low) inside
                        rie_pkg::F3_CMPEQ: st_out.t = (rn == rm);
                        rie_pkg::F3_CMPHS: st_out.t = (rn >= rm);
                        rie_pkg::F3_CMPGE: st_out.t = ($signed(rn) >= $signed(rm));
                        rie_pkg::F3_DIV1:
                        begin
                            res      = 1'b1;
                            newv     = after;
                            st_out.q = dq;
                            st_out.t = (dq == st_in.m);
                        end
                        rie_pkg::F3_DMULU, rie_pkg::F3_DMULS:
                        begin
                            st_out.mach = prod[63:32];
                            st_out.macl = prod[31:0];
                            wb.cost     = rie_pkg::COST_MUL;
                        end
                        rie_pkg::F3_CMPHI: st_out.t = (rn > rm);
                        rie_pkg::F3_CMPGT: st_out.t = ($signed(rn) > $signed(rm));
                        rie_pkg::F3_SUB:
                        begin
                            res  = 1'b1;
                            newv = d;
                        end
                        rie_pkg::F3_SUBC:
                        begin
                            res      = 1'b1;
                            newv     = r;
                            st_out.t = (rn < d) || (d < r);
                        end
                        rie_pkg::F3_ADD:
                        begin
                            res  = 1'b1;
                            newv = rn + rm;
                        end
                        rie_pkg::F3_ADDC:
                        begin
                            res      = 1'b1;
                            newv     = r;
                            st_out.t = (rn > (rn + rm)) || ((rn + rm) > r);
                        end
                        default: wb.ill = 1'b1;
                    endcase
                end
                else if (top == rie_pkg::GRP_7)
                begin
                    res  = 1'b1;
                    newv = rn + imm;
                end
                else if (instr[15:8] == rie_pkg::HI_CMPEQI)
                begin
                    st_out.t = (rm == imm);
                end
                else if (top == rie_pkg::GRP_6)
                begin
                    res = 1'b1;
                    unique case (low)
                        rie_pkg::F6_NEGC:
                        begin
                            newv     = r;
                            st_out.t = (z != 32'd0) || (z < r);
                        end
                        rie_pkg::F6_NEG:   newv = z;
                        rie_pkg::F6_EXTUB: newv = {24'd0, rm[7:0]};
                        rie_pkg::F6_EXTUW: newv = {16'd0, rm[15:0]};
                        rie_pkg::F6_EXTSB: newv = {{24{rm[7]}}, rm[7:0]};
                        rie_pkg::F6_EXTSW: newv = {{16{rm[15]}}, rm[15:0]};
                        default:
                        begin
                            res    = 1'b0;
                            wb.ill = 1'b1;
                        end
                    endcase
                end
                else if (top == rie_pkg::GRP_2)
                begin
                    unique case (low) inside
                        rie_pkg::F2_DIV0S:
                        begin
                            st_out.q = rn[31];
                            st_out.m = rm[31];
                            st_out.t = rn[31] ^ rm[31];
                        end
                        rie_pkg::F2_CMPSTR:
                            st_out.t = (x[31:24] == 8'd0) || (x[23:16] == 8'd0) ||
                                       (x[15:8] == 8'd0) || (x[7:0] == 8'd0);
                        rie_pkg::F2_MULUW, rie_pkg::F2_MULSW:
                        begin
                            st_out.macl = prod[31:0];
                            wb.cost     = rie_pkg::COST_MUL;
                        end
                        default: wb.ill = 1'b1;
                    endcase
                end
                else if (top == rie_pkg::GRP_4 && instr[7:0] == rie_pkg::F4_DT)
                begin
                    res      = 1'b1;
                    newv     = dec;
                    st_out.t = (dec == 32'd0);
                end
                else if (top == rie_pkg::GRP_4 && instr[7:0] == rie_pkg::F4_CMPPZ)
                begin
                    st_out.t = ~rn[31];
                end
                else if (top == rie_pkg::GRP_4 && instr[7:0] == rie_pkg::F4_CMPPL)
                begin
                    st_out.t = ~rn[31] && (rn != 32'd0);
                end
                else if (top == rie_pkg::GRP_0 && low == rie_pkg::F0_MULL)
                begin
                    st_out.macl = prod[31:0];
                    wb.cost     = rie_pkg::COST_MUL;
                end
                else if (instr == rie_pkg::W_DIV0U)
                begin
                    st_out.q = 1'b0;
                    st_out.m = 1'b0;
                    st_out.t = 1'b0;
                end
                else
                begin
                    wb.ill = 1'b1;
                end
                if (wb.ill)
                begin
                    wb.cost = rie_pkg::COST_NONE;
                end
                if (res)
                begin
                    wb.wr   = 1'b1;
                    wb.dest = n;
                    wb.data = newv;
                end
            end
            default: ;
        endcase
    end

endmodule

>>> sv/risc_integer_arith_execute_core.sv
// ----------------------------------------------------------------------------
// risc_integer_arith_execute_core: integer arithmetic execute unit
// sixteen 32-bit registers, T/Q/M flags and 64-bit multiply accumulator
// ----------------------------------------------------------------------------
// One word is taken per clock while the input is not stalled. The register file
// is read as a word is accepted into the input register; the datapath then sits
// between the input register and the result register, which loads the result
// as the word moves on. Register writes are forwarded into the operand capture
// and the flags are read straight from the state register, so dependent words
// run back to back at one per clock while the output is not stalled. A stalled
// result holds, and the input stalls only while the input register is full and
// its word cannot move on. The single 33x33 multiplier sets the longest path.
module risc_integer_arith_execute_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [15:0] instr,
    input  logic [3:0]  reg_index,
    input  logic [31:0] reg_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        reg_write,
    output logic [3:0]  reg_dest,
    output logic [31:0] reg_data,
    output logic        t_bit,
    output logic        q_bit,
    output logic        m_bit,
    output logic [31:0] mac_high,
    output logic [31:0] mac_low,
    output logic        illegal,
    output logic [2:0]  cost_cycles
);

    logic [31:0]      regs [rie_pkg::NUM_REGS];
    logic             s1_valid_reg;
    rie_pkg::op_t     s1_op_reg;
    logic [15:0]      s1_instr_reg;
    logic [3:0]       s1_idx_reg;
    logic [31:0]      s1_val_reg;
    logic [31:0]      s1_rn_reg;
    logic [31:0]      s1_rm_reg;
    rie_pkg::flags_t  st_reg;
    rie_pkg::flags_t  st_next;
    rie_pkg::wb_t     wb_next;
    rie_pkg::wb_t     wb_reg;
    logic             out_valid_reg;
    logic             advance;
    logic             accept;
    logic [3:0]       addr_a;
    logic [3:0]       addr_b;
    logic             wr_en;

    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;
    assign wr_en    = advance && wb_next.wr;

    assign addr_a = (rie_pkg::op_t'(operation) == rie_pkg::OP_EXEC) ? instr[11:8] : reg_index;
    assign addr_b = (instr[15:8] == rie_pkg::HI_CMPEQI) ? 4'd0 : instr[7:4];

    rie_alu u_alu (
        .op     (s1_op_reg),
        .instr  (s1_instr_reg),
        .idx    (s1_idx_reg),
        .val    (s1_val_reg),
        .rn     (s1_rn_reg),
        .rm     (s1_rm_reg),
        .st_in  (st_reg),
        .st_out (st_next),
        .wb     (wb_next)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg    <= rie_pkg::op_t'(operation);
            s1_instr_reg <= instr;
            s1_idx_reg   <= reg_index;
            s1_val_reg   <= reg_value;
            s1_rn_reg    <= (wr_en && wb_next.dest == addr_a) ? wb_next.data : regs[addr_a];
            s1_rm_reg    <= (wr_en && wb_next.dest == addr_b) ? wb_next.data : regs[addr_b];
        end
        if (advance)
        begin
            wb_reg <= wb_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= '0;
            regs          <= '{default: '0};
        end
        else
        begin
            if (wr_en)
            begin
                regs[wb_next.dest] <= wb_next.data;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                st_reg        <= st_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign reg_write   = wb_reg.wr;
    assign reg_dest    = wb_reg.dest;
    assign reg_data    = wb_reg.data;
    assign illegal     = wb_reg.ill;
    assign cost_cycles = wb_reg.cost;
    assign t_bit       = st_reg.t;
    assign q_bit       = st_reg.q;
    assign m_bit       = st_reg.m;
    assign mac_high    = st_reg.mach;
    assign mac_low     = st_reg.macl;

endmodule
